FILE: rtl/fully_assoc_cache_tag_lookup_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fully associative cache tag lookup core.
// The checks compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FULLY_ASSOC_CACHE_TAG_LOOKUP_CORE_MACROS_SVH
`define FULLY_ASSOC_CACHE_TAG_LOOKUP_CORE_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define FACL_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("facl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FACL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("facl assertion failed");

`else

`define FACL_ASSERT_SAME(label, ante, cons)
`define FACL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/facl_pkg.sv
// ----------------------------------------------------------------------------
// facl_pkg
// Shared constants for the fully associative cache tag lookup core: default
// geometry and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
package facl_pkg;

	// Default geometry.
	localparam int NUM_LINES_DEF   = 16;
	localparam int OFFSET_BITS_DEF = 4;
	localparam int ADDR_BITS_DEF   = 32;

	// Fixed field widths of the input and result items.
	localparam int ADDR_W     = 32;
	localparam int LINE_IDX_W = 4;
	localparam int VICTIM_W   = 28;
	localparam int COUNT_W    = 32;

endpackage

FILE: rtl/fully_assoc_cache_tag_lookup_core.sv
// ----------------------------------------------------------------------------
// fully_assoc_cache_tag_lookup_core
// Datapath: the input register, then the compare and update, then the result register.
// Throughput: one item per cycle while out_ready does not hold the result register full.
// Reset: arst_n clears all lines to invalid, recency ranks and both counters.
// ----------------------------------------------------------------------------
`include "fully_assoc_cache_tag_lookup_core_macros.svh"

module fully_assoc_cache_tag_lookup_core #(
	parameter int NUM_LINES   = facl_pkg::NUM_LINES_DEF,
	parameter int OFFSET_BITS = facl_pkg::OFFSET_BITS_DEF,
	parameter int ADDR_BITS   = facl_pkg::ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input channel.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [facl_pkg::ADDR_W-1:0]     address,
	// Result channel.
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic                            filled_free,
	output logic                            evicted,
	output logic [facl_pkg::LINE_IDX_W-1:0] line_index,
	output logic [facl_pkg::VICTIM_W-1:0]   victim_tag,
	output logic [facl_pkg::COUNT_W-1:0]    hit_total,
	output logic [facl_pkg::COUNT_W-1:0]    access_total
);

	localparam int TAG_W  = ADDR_BITS - OFFSET_BITS;
	localparam int LIDX_W = $clog2(NUM_LINES);
	localparam int RANK_W = $clog2(NUM_LINES);
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_LINES - 1);

	// Input stage.
	logic                 valid_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic                 advance_s1;

	// Line state.
	logic [NUM_LINES-1:0] line_valid_q;
	logic [TAG_W-1:0]     line_tag_q [NUM_LINES];
	logic [RANK_W-1:0]    rank_q     [NUM_LINES];
	logic [RANK_W-1:0]    rank_d     [NUM_LINES];
	logic [facl_pkg::COUNT_W-1:0] hit_cnt_q;
	logic [facl_pkg::COUNT_W-1:0] acc_cnt_q;

	// Lookup results.
	logic [NUM_LINES-1:0] hit_vec;
	logic [NUM_LINES-1:0] free_vec;
	logic [NUM_LINES-1:0] oldest_vec;
	logic                 any_hit;
	logic                 any_free;
	logic [LIDX_W-1:0]    hit_idx;
	logic [LIDX_W-1:0]    free_idx;
	logic [LIDX_W-1:0]    old_idx;
	logic [LIDX_W-1:0]    sel_idx;
	logic                 age_all;
	logic [RANK_W-1:0]    old_rank;
	logic [TAG_W-1:0]     victim_d;

	// Result register.
	logic                           out_valid_q;
	logic                           hit_q;
	logic                           filled_q;
	logic                           evicted_q;
	logic [facl_pkg::LINE_IDX_W-1:0] line_index_q;
	logic [facl_pkg::VICTIM_W-1:0]  victim_tag_q;
	logic [facl_pkg::COUNT_W-1:0]   hit_total_q;
	logic [facl_pkg::COUNT_W-1:0]   access_total_q;
	logic [2:0]                     kind_vec;

	// Handshake: the input stage moves on whenever the result register is free or drains.
	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	// The tag drops the offset bits of the address, limited to the configured width.
	assign tag_s1 = addr_s1[ADDR_BITS-1:OFFSET_BITS];

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			addr_s1 <= ADDR_BITS'(address);
		end
	end

	// Parallel compare across all lines, with lowest-index priority picks.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		old_idx  = '0;
		for (int i = 0; i < NUM_LINES; i++) begin
			hit_vec[i]    = line_valid_q[i] && (line_tag_q[i] == tag_s1);
			free_vec[i]   = !line_valid_q[i];
			oldest_vec[i] = rank_q[i] == RANK_MAX;
		end
		for (int i = NUM_LINES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = LIDX_W'(i);
			end
			if (free_vec[i]) begin
				free_idx = LIDX_W'(i);
			end
			if (oldest_vec[i]) begin
				old_idx = LIDX_W'(i);
			end
		end
		any_hit  = |hit_vec;
		any_free = |free_vec;
	end

	// Pick the line: the hit, else the first free line, else the least recently used.
	always_comb begin
		if (any_hit) begin
			sel_idx = hit_idx;
		end else if (any_free) begin
			sel_idx = free_idx;
		end else begin
			sel_idx = old_idx;
		end
		age_all  = !any_hit && any_free;
		old_rank = rank_q[sel_idx];
		victim_d = (!any_hit && !any_free) ? line_tag_q[sel_idx] : '0;
	end

	// Recency update: the chosen line becomes youngest; younger valid lines age, on a fill all valid lines.
	always_comb begin
		for (int i = 0; i < NUM_LINES; i++) begin
			if (LIDX_W'(i) == sel_idx) begin
				rank_d[i] = '0;
			end else if (line_valid_q[i] && (age_all || rank_q[i] < old_rank)) begin
				rank_d[i] = rank_q[i] + RANK_W'(1);
			end else begin
				rank_d[i] = rank_q[i];
			end
		end
	end

	// Line valid bits, recency ranks and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= '0;
			hit_cnt_q    <= '0;
			acc_cnt_q    <= '0;
			for (int i = 0; i < NUM_LINES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (advance_s1) begin
			rank_q    <= rank_d;
			acc_cnt_q <= acc_cnt_q + facl_pkg::COUNT_W'(1);
			if (any_hit) begin
				hit_cnt_q <= hit_cnt_q + facl_pkg::COUNT_W'(1);
			end else begin
				line_valid_q[sel_idx] <= 1'b1;
			end
		end
	end

	// Tag storage is written on every miss.
	always_ff @(posedge clk) begin
		if (advance_s1 && !any_hit) begin
			line_tag_q[sel_idx] <= tag_s1;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			hit_q          <= any_hit;
			filled_q       <= age_all;
			evicted_q      <= !any_hit && !any_free;
			line_index_q   <= facl_pkg::LINE_IDX_W'(sel_idx);
			victim_tag_q   <= facl_pkg::VICTIM_W'(victim_d);
			hit_total_q    <= any_hit ? hit_cnt_q + facl_pkg::COUNT_W'(1) : hit_cnt_q;
			access_total_q <= acc_cnt_q + facl_pkg::COUNT_W'(1);
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign filled_free  = filled_q;
	assign evicted      = evicted_q;
	assign line_index   = line_index_q;
	assign victim_tag   = victim_tag_q;
	assign hit_total    = hit_total_q;
	assign access_total = access_total_q;

	assign kind_vec = {hit_q, filled_q, evicted_q};

	// Every result is exactly one of hit, fill or eviction.
	`FACL_ASSERT_SAME(a_one_kind, out_valid_q, $onehot(kind_vec))
	// With every line valid, exactly one line holds the oldest rank.
	`FACL_ASSERT_SAME(a_one_oldest, &line_valid_q, $onehot(oldest_vec))
	// Each item that leaves the input stage bumps the access counter by one.
	`FACL_ASSERT_NEXT(a_acc_count, advance_s1, acc_cnt_q == $past(acc_cnt_q) + 1)
	// A victim tag is reported only on an eviction.
	`FACL_ASSERT_SAME(a_victim_zero, out_valid_q && !evicted_q, victim_tag_q == '0)

endmodule
